// File: sv/motor_board_register_model_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor board register model
// Implication and next-cycle checks clocked on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef MOTOR_BOARD_REGISTER_MODEL_UNIT_MACROS_SVH
`define MOTOR_BOARD_REGISTER_MODEL_UNIT_MACROS_SVH

// Same-cycle implication
`define MBR_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication
`define MBR_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: sv/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types and constants of the motor board register model.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int DefMotorCount = 4;
  localparam int WordCount = 32;
  localparam int AddrW = 5;
  localparam int WordW = 16;

  localparam logic [AddrW-1:0] WORDS_PER_MOTOR = 5'd6;
  localparam logic [AddrW-1:0] TOTAL_WORD = 5'd24;
  localparam logic [AddrW-1:0] ARMED_WORD = 5'd28;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_REFRESH = 2'd3
  } mbr_mode_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_LAG_GAIN  = 8'd0;
  localparam logic [7:0] CFG_SNAP      = 8'd1;
  localparam logic [7:0] CFG_AMPS      = 8'd2;
  localparam logic [7:0] CFG_BATTERY   = 8'd3;

  localparam logic [15:0] RST_LAG_GAIN = 16'd16384;
  localparam logic [15:0] RST_SNAP     = 16'd655;
  localparam logic [15:0] RST_AMPS     = 16'd3277;
  localparam logic [31:0] RST_BATTERY  = 32'd1572864;

  typedef struct packed {
    logic [15:0] lag_gain;
    logic [15:0] snap_threshold;
    logic [15:0] amps_per_rps;
    logic [31:0] battery_voltage;
  } mbr_cfg_t;

  // One write port and one read port of the register file
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [WordW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mbr_mem_req_t;

endpackage

// File: sv/motor_board_register_model_unit.sv
// ----------------------------------------------------------------------------
// motor_board_register_model_unit
// Register map of a four-motor drive board with a lag model of the motors.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*: tuser is the item kind (read, write, tick,
// refresh), tdata the word address and write word. Every item gives exactly
// one word on m_t*: the addressed word for a read, zero otherwise.
// Configuration registers are written on cfg_valid/cfg_index/cfg_data,
// always ready, and are meant to change only while the block is idle.
// One item is in work at a time, all register words live in a single-port-write,
// single-port-read register file. A tick or refresh walks each motor's words
// through the one read port and the one write port, with two shared multiplies
// per motor, then writes the four status words.
// A finished word waits in the output register while the next item is
// accepted; if the receiver stalls, the block holds its next result until
// the output register frees up. Reset clears all words to zero (through
// per-word valid bits, no clearing pass) and restores register defaults.
// ----------------------------------------------------------------------------
module motor_board_register_model_unit import mbr_pkg::*; #(
  parameter int MOTOR_COUNT = DefMotorCount
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [4:0] reg_addr, [20:5] write_data, [23:21] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] read_data
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_ARM, S_RHI, S_RLO, S_DIFF, S_MUL1, S_MOVE, S_SNAP,
    S_MUL2, S_WSLO, S_WCHI, S_WCLO, S_WT0, S_WT1, S_WT2, S_WT3, S_DONE
  } state_t;

  localparam logic [1:0] LAST_MOTOR = 2'(MOTOR_COUNT - 1);

  state_t           state;
  mbr_cfg_t         cfg;
  mbr_mem_req_t     req;
  logic [WordW-1:0] rdata;

  logic [1:0]       motor;
  logic             moving;
  logic             armed;
  logic [15:0]      setp;
  logic [15:0]      spd_hi;
  logic [31:0]      speed;
  logic [31:0]      target;
  logic [31:0]      delta;
  logic             up;
  logic [31:0]      step;
  logic [31:0]      cur;
  logic [33:0]      total;
  logic [15:0]      result;

  logic [AddrW-1:0] base;
  logic             in_acc;
  mbr_mode_t        mode;
  logic [AddrW-1:0] in_addr;
  logic [15:0]      in_data;
  logic [31:0]      speed_v;
  logic [31:0]      target_v;
  logic [31:0]      snap_d;
  logic [47:0]      prod1;
  logic [47:0]      prod2;
  logic [31:0]      total_sat;

  mbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbr_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign mode     = mbr_mode_t'(s_tuser);
  assign in_addr  = s_tdata[4:0];
  assign in_data  = s_tdata[20:5];

  assign base      = 5'(motor) * WORDS_PER_MOTOR;
  assign speed_v   = {spd_hi, rdata};
  assign target_v  = armed ? {setp, 16'd0} : 32'd0;
  assign snap_d    = (speed >= target) ? (speed - target) : (target - speed);
  assign prod1     = 48'(delta) * 48'(cfg.lag_gain);
  assign prod2     = 48'(speed) * 48'(cfg.amps_per_rps);
  assign total_sat = (total[33:32] != 2'd0) ? 32'hFFFF_FFFF : total[31:0];

  // Memory port per state
  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        req.we    = in_acc && (mode == MODE_WRITE);
        req.waddr = in_addr;
        req.wdata = in_data;
        req.raddr = (mode == MODE_READ) ? in_addr : ARMED_WORD;
      end
      S_ARM: req.raddr = base;
      S_RHI: req.raddr = base + 5'd2;
      S_RLO: req.raddr = base + 5'd3;
      S_MUL2: begin
        req.we    = 1'b1;
        req.waddr = base + 5'd2;
        req.wdata = speed[31:16];
      end
      S_WSLO: begin
        req.we    = 1'b1;
        req.waddr = base + 5'd3;
        req.wdata = speed[15:0];
      end
      S_WCHI: begin
        req.we    = 1'b1;
        req.waddr = base + 5'd4;
        req.wdata = cur[31:16];
      end
      S_WCLO: begin
        req.we    = 1'b1;
        req.waddr = base + 5'd5;
        req.wdata = cur[15:0];
        req.raddr = base + WORDS_PER_MOTOR;
      end
      S_WT0: begin
        req.we    = 1'b1;
        req.waddr = TOTAL_WORD;
        req.wdata = total_sat[31:16];
      end
      S_WT1: begin
        req.we    = 1'b1;
        req.waddr = TOTAL_WORD + 5'd1;
        req.wdata = total_sat[15:0];
      end
      S_WT2: begin
        req.we    = 1'b1;
        req.waddr = TOTAL_WORD + 5'd2;
        req.wdata = cfg.battery_voltage[31:16];
      end
      S_WT3: begin
        req.we    = 1'b1;
        req.waddr = TOTAL_WORD + 5'd3;
        req.wdata = cfg.battery_voltage[15:0];
      end
      default: ;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      motor    <= 2'd0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            motor  <= 2'd0;
            total  <= '0;
            moving <= (mode == MODE_TICK);
            result <= '0;
            unique case (mode)
              MODE_READ:  state <= S_READ;
              MODE_WRITE: state <= S_DONE;
              default:    state <= S_ARM;
            endcase
          end
        end
        S_READ: begin
          result <= rdata;
          state  <= S_DONE;
        end
        S_ARM: begin
          armed <= (rdata != '0);
          state <= S_RHI;
        end
        S_RHI: begin
          setp  <= rdata;
          state <= S_RLO;
        end
        S_RLO: begin
          spd_hi <= rdata;
          state  <= S_DIFF;
        end
        // Distance and direction toward the target
        S_DIFF: begin
          speed  <= speed_v;
          target <= target_v;
          up     <= (target_v >= speed_v);
          delta  <= (target_v >= speed_v) ? (target_v - speed_v) : (speed_v - target_v);
          state  <= S_MUL1;
        end
        S_MUL1: begin
          step  <= moving ? prod1[47:16] : 32'd0;
          state <= S_MOVE;
        end
        S_MOVE: begin
          speed <= up ? (speed + step) : (speed - step);
          state <= S_SNAP;
        end
        S_SNAP: begin
          if (snap_d < 32'(cfg.snap_threshold)) begin
            speed <= target;
          end
          state <= S_MUL2;
        end
        S_MUL2: begin
          cur   <= prod2[47:16];
          state <= S_WSLO;
        end
        S_WSLO: begin
          total <= total + 34'(cur);
          state <= S_WCHI;
        end
        S_WCHI: state <= S_WCLO;
        S_WCLO: begin
          if (motor == LAST_MOTOR) begin
            state <= S_WT0;
          end else begin
            motor <= motor + 2'd1;
            state <= S_RHI;
          end
        end
        S_WT0: state <= S_WT1;
        S_WT1: state <= S_WT2;
        S_WT2: state <= S_WT3;
        S_WT3: state <= S_DONE;
        // Hand the word to the output register once it is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/mbr_cfg.sv
// ----------------------------------------------------------------------------
// mbr_cfg
// Configuration registers: decode the write channel and hold the values.
// ----------------------------------------------------------------------------
module mbr_cfg import mbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output mbr_cfg_t    cfg
);

  assign cfg_ready = 1'b1;

  // Load the addressed register; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lag_gain        <= RST_LAG_GAIN;
      cfg.snap_threshold  <= RST_SNAP;
      cfg.amps_per_rps    <= RST_AMPS;
      cfg.battery_voltage <= RST_BATTERY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LAG_GAIN: cfg.lag_gain        <= cfg_data[15:0];
        CFG_SNAP:     cfg.snap_threshold  <= cfg_data[15:0];
        CFG_AMPS:     cfg.amps_per_rps    <= cfg_data[15:0];
        CFG_BATTERY:  cfg.battery_voltage <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/mbr_regfile.sv
// ----------------------------------------------------------------------------
// mbr_regfile
// 32-word register file: synchronous memory with a registered read and a
// valid bit per word so that words never written read as zero.
// ----------------------------------------------------------------------------
module mbr_regfile import mbr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mbr_mem_req_t     req,
  output logic [WordW-1:0] rdata
);

  logic [WordW-1:0] mem [WordCount];
  logic [WordCount-1:0] valid;
  logic [WordW-1:0] q;
  logic             q_valid;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q <= mem[req.raddr];
  end

  // Track written words
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      q_valid <= valid[req.raddr];
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = q_valid ? q : '0;

endmodule

// File: sv/mbr_checker.sv
// ----------------------------------------------------------------------------
// mbr_checker
// Port-level checks of the motor board register model, bound to the top.
// ----------------------------------------------------------------------------
`include "motor_board_register_model_unit_macros.svh"

module mbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Count accepted words not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  `MBR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `MBR_ASSERT_IMP(a_no_extra, out_acc, pending != 2'd0, "output word without an accepted input")
  `MBR_ASSERT_IMP(a_bounded, 1'b1, pending != 2'd3, "more than two words in flight")
  `MBR_ASSERT_IMP(a_reset_clear, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

bind motor_board_register_model_unit mbr_checker u_mbr_checker (.*);

// File: tb/sv/tb_motor_board_register_model_unit.sv
// ----------------------------------------------------------------------------
// tb_motor_board_register_model_unit
// Self-checking bench for the motor board register map and its lag model.
// ----------------------------------------------------------------------------
// A queue of bus items (read, write, tick, refresh) feeds a stream driver.
// The monitor runs an in-bench model of the register file on every accepted
// input word and checks each output word against the oldest prediction.
// Configuration is rewritten between phases once the block has drained:
// defaults, both extremes, random values and ignored indexes. Random traffic
// is mostly setpoint/arm/tick sequences with reads of the derived words.
// ----------------------------------------------------------------------------
module tb_motor_board_register_model_unit import mbr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MotorCount  = DefMotorCount;
  localparam int CycleLimit  = 2000000;
  localparam int PhaseItems  = 320;
  localparam int ChunkItems  = 80;
  localparam int DrainCycles = 60;

  typedef struct {
    mbr_mode_t       mode;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] data;
  } bus_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [4:0] reg_addr, [20:5] write_data, [23:21] zero
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] read_data
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Pending input words and predicted output words
  bus_item_t        bus_items[$];
  logic [WordW-1:0] read_words_due[$];

  // Model of the board: register file and configuration
  logic [WordW-1:0] board_words[WordCount];
  logic [15:0]      lag_q;
  logic [15:0]      snap_q;
  logic [15:0]      amps_q;
  logic [31:0]      battery_q;

  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;
  bit   calm     = 1'b0;
  int   errors   = 0;
  int   queued_count = 0;
  int   cycle_count  = 0;

  motor_board_register_model_unit #(
    .MOTOR_COUNT(MotorCount)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Move every motor one step (or only snap on a refresh), then rebuild the
  // current, total current and battery words
  function automatic void board_advance(input bit moving);
    bit          armed;
    int          base;
    logic [33:0] total;
    logic [31:0] target;
    logic [31:0] speed;
    logic [31:0] delta;
    logic [31:0] amps_now;
    logic [63:0] prod;
    armed = (board_words[ARMED_WORD] != '0);
    total = '0;
    for (int m = 0; m < MotorCount; m++) begin
      base   = m * int'(WORDS_PER_MOTOR);
      target = armed ? {board_words[base], 16'h0000} : 32'h0;
      speed  = {board_words[base+2], board_words[base+3]};
      if (moving) begin
        if (target >= speed) begin
          prod  = 64'(target - speed) * 64'(lag_q);
          speed = speed + prod[47:16];
        end else begin
          prod  = 64'(speed - target) * 64'(lag_q);
          speed = speed - prod[47:16];
        end
      end
      delta = (speed >= target) ? speed - target : target - speed;
      if (delta < {16'h0000, snap_q}) speed = target;
      prod     = 64'(speed) * 64'(amps_q);
      amps_now = prod[47:16];
      board_words[base+2] = speed[31:16];
      board_words[base+3] = speed[15:0];
      board_words[base+4] = amps_now[31:16];
      board_words[base+5] = amps_now[15:0];
      total = total + 34'(amps_now);
    end
    if (total > 34'h0_FFFF_FFFF) total = 34'h0_FFFF_FFFF;
    board_words[TOTAL_WORD]   = total[31:16];
    board_words[TOTAL_WORD+1] = total[15:0];
    board_words[TOTAL_WORD+2] = battery_q[31:16];
    board_words[TOTAL_WORD+3] = battery_q[15:0];
  endfunction

  // Apply one bus item to the model and return the word it reads back
  function automatic logic [WordW-1:0] board_access(input mbr_mode_t mode,
                                                    input logic [AddrW-1:0] addr,
                                                    input logic [WordW-1:0] data);
    logic [WordW-1:0] word;
    word = '0;
    case (mode)
      MODE_READ:  word = board_words[addr];
      MODE_WRITE: board_words[addr] = data;
      MODE_TICK:  board_advance(1'b1);
      default:    board_advance(1'b0);
    endcase
    return word;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(input mbr_mode_t mode, input logic [AddrW-1:0] addr,
                          input logic [WordW-1:0] data);
    bus_item_t it;
    it.mode = mode;
    it.addr = addr;
    it.data = data;
    bus_items.push_back(it);
    queued_count++;
  endtask

  // Tick or refresh with random address and data bits riding along
  task automatic add_update(input mbr_mode_t mode);
    add_item(mode, AddrW'($urandom), WordW'($urandom));
  endtask

  function automatic logic [WordW-1:0] pick_setpoint();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return WordW'($urandom);
    if (r < 60) return WordW'($urandom_range(0, 50));
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return WordW'($urandom_range(1, 1000));
  endfunction

  // Speed, current or status word
  function automatic logic [AddrW-1:0] pick_motion_word();
    if ($urandom_range(0, 4) == 0) return TOTAL_WORD + AddrW'($urandom_range(0, 3));
    return AddrW'($urandom_range(0, MotorCount-1) * int'(WORDS_PER_MOTOR)
                  + $urandom_range(2, 5));
  endfunction

  // Queue n random items, mostly setpoint/arm/tick sequences
  task automatic queue_random_run(input int n);
    int goal;
    int pick;
    int m;
    logic [AddrW-1:0] a;
    goal = queued_count + n;
    while (queued_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 4)) begin
          m = $urandom_range(0, MotorCount-1);
          add_item(MODE_WRITE, AddrW'(m * int'(WORDS_PER_MOTOR)), pick_setpoint());
        end
        add_item(MODE_WRITE, ARMED_WORD,
                 ($urandom_range(0, 4) != 0) ? WordW'($urandom_range(1, 65535)) : '0);
        repeat ($urandom_range(1, 12)) begin
          add_update(MODE_TICK);
          if ($urandom_range(0, 2) == 0) add_item(MODE_READ, pick_motion_word(), '0);
        end
        if ($urandom_range(0, 4) == 0) add_update(MODE_REFRESH);
        repeat (2) add_item(MODE_READ, pick_motion_word(), WordW'($urandom));
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 4)) add_item(MODE_READ, AddrW'($urandom), WordW'($urandom));
      end else if (pick < 75) begin
        // Overwrite any word, derived ones included, and read it back
        a = AddrW'($urandom);
        add_item(MODE_WRITE, a, WordW'($urandom));
        if ($urandom_range(0, 1) != 0) add_update(MODE_REFRESH);
        add_item(MODE_READ, a, WordW'($urandom));
      end else if (pick < 85) begin
        add_item(MODE_WRITE, ARMED_WORD, '0);
        repeat ($urandom_range(1, 6)) add_update(MODE_TICK);
        add_item(MODE_READ, pick_motion_word(), '0);
      end else begin
        add_item(mbr_mode_t'($urandom_range(0, 3)), AddrW'($urandom), WordW'($urandom));
      end
    end
  endtask

  // Hold until every queued word went in and every result came back
  task automatic wait_idle();
    do @(negedge clk);
    while (bus_items.size() != 0 || read_words_due.size() != 0 || s_tvalid);
  endtask

  task automatic set_register(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: hold a word until taken, then idle or present the next
  always @(negedge clk) begin : drive_proc
    bus_item_t nxt;
    static int send_gap = 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_took) begin
      s_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap--;
    end else if (bus_items.size() == 0) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt = bus_items.pop_front();
      s_tuser  <= nxt.mode;
      s_tdata  <= {3'b000, nxt.data, nxt.addr};
      s_tvalid <= 1'b1;
      send_gap = pick_gap();
    end
  end

  // Output stall pattern
  always @(negedge clk) begin : ready_proc
    static int stall = 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall > 0) begin
      m_tready <= 1'b0;
      stall--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall = pick_gap();
    end
  end

  // Monitor: check output words, then predict for newly accepted input words
  always @(posedge clk) begin : watch_proc
    logic [WordW-1:0] due;
    in_took  <= s_tvalid && s_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst) begin
      // Hold the model at its reset contents
      for (int w = 0; w < WordCount; w++) board_words[w] = '0;
      lag_q     = RST_LAG_GAIN;
      snap_q    = RST_SNAP;
      amps_q    = RST_AMPS;
      battery_q = RST_BATTERY;
    end else begin
      if (m_tvalid && m_tready) begin
        if (read_words_due.size() == 0) begin
          flag_mismatch($sformatf("read_data 0x%04h with nothing pending", m_tdata));
        end else begin
          due = read_words_due.pop_front();
          if (m_tdata !== due)
            flag_mismatch($sformatf("read_data 0x%04h, want 0x%04h", m_tdata, due));
        end
      end
      if (s_tvalid && s_tready)
        read_words_due.push_back(board_access(mbr_mode_t'(s_tuser), s_tdata[4:0],
                                              s_tdata[20:5]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAG_GAIN: lag_q     = cfg_data[15:0];
          CFG_SNAP:     snap_q    = cfg_data[15:0];
          CFG_AMPS:     amps_q    = cfg_data[15:0];
          CFG_BATTERY:  battery_q = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin : limit_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stim_proc
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset contents, extremes, derived-word overwrite, disarm
    add_item(MODE_READ,    5'd31, 16'h0000);
    add_item(MODE_WRITE,   5'd31, 16'hFFFF);
    add_item(MODE_READ,    5'd31, 16'hFFFF);
    add_item(MODE_WRITE,   5'd0,  16'hFFFF);
    add_item(MODE_WRITE,   5'd18, 16'h0001);
    add_item(MODE_WRITE,   5'd1,  16'hA5A5);
    add_item(MODE_WRITE,   ARMED_WORD, 16'h0001);
    add_item(MODE_TICK,    5'd0,  16'h0000);
    for (int w = 2; w < 6; w++) add_item(MODE_READ, AddrW'(w), 16'h0000);
    for (int w = 0; w < 4; w++) add_item(MODE_READ, TOTAL_WORD + AddrW'(w), 16'h0000);
    add_item(MODE_WRITE,   TOTAL_WORD, 16'h1234);
    add_item(MODE_READ,    TOTAL_WORD, 16'h0000);
    add_item(MODE_REFRESH, 5'd31, 16'hFFFF);
    add_item(MODE_READ,    TOTAL_WORD, 16'h0000);
    add_item(MODE_READ,    5'd1,  16'h0000);
    add_item(MODE_WRITE,   ARMED_WORD, 16'h0000);
    add_item(MODE_TICK,    5'd31, 16'hFFFF);
    add_item(MODE_READ,    5'd20, 16'h0000);
    add_item(MODE_READ,    5'd2,  16'h0000);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          set_register(CFG_LAG_GAIN, 32'h0000_FFFF);
          set_register(CFG_SNAP,     32'h0000_0000);
          set_register(CFG_AMPS,     32'h0000_FFFF);
          set_register(CFG_BATTERY,  32'hFFFF_FFFF);
          set_register(8'd4,         32'h1234_5678);
          set_register(8'd255,       32'hFFFF_FFFF);
        end
        1: begin
          // Upper bits of the narrow registers must be dropped
          set_register(CFG_LAG_GAIN, 32'hFFFF_0000);
          set_register(CFG_SNAP,     32'hABCD_FFFF);
          set_register(CFG_AMPS,     32'h8000_0000);
          set_register(CFG_BATTERY,  32'h0000_0000);
        end
        2: begin
          set_register(CFG_LAG_GAIN, $urandom);
          set_register(CFG_SNAP,     $urandom);
          set_register(CFG_AMPS,     $urandom);
          set_register(CFG_BATTERY,  $urandom);
        end
        3: begin
          set_register(CFG_LAG_GAIN, $urandom_range(1, 65535));
          set_register(CFG_SNAP,     $urandom_range(0, 100));
          set_register(CFG_AMPS,     $urandom);
          set_register(CFG_BATTERY,  $urandom);
          set_register(8'($urandom_range(4, 255)), $urandom);
        end
        default: begin
          set_register(CFG_LAG_GAIN, 32'(RST_LAG_GAIN));
          set_register(CFG_SNAP,     32'(RST_SNAP));
          set_register(CFG_AMPS,     32'(RST_AMPS));
          set_register(CFG_BATTERY,  RST_BATTERY);
        end
      endcase

      // Drive the total current into saturation under the high extremes
      if (p == 0) begin
        for (int m = 0; m < MotorCount; m++)
          add_item(MODE_WRITE, AddrW'(m * int'(WORDS_PER_MOTOR)), 16'hFFFF);
        add_item(MODE_WRITE, ARMED_WORD, 16'hFFFF);
        repeat (3) add_update(MODE_TICK);
        for (int w = 0; w < 4; w++) add_item(MODE_READ, TOTAL_WORD + AddrW'(w), 16'h0000);
      end

      // Random traffic in chunks; the sender drains fully after each one
      for (int c = 0; c < PhaseItems / ChunkItems; c++) begin
        calm = ($urandom_range(0, 3) == 0);
        queue_random_run(ChunkItems);
        wait_idle();
      end
      calm = 1'b0;
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
